// ----- hdl/pfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Particle frame parser and averager package
// Request and result codes, frame layout and field widths shared by the
// block and its users.
// ----------------------------------------------------------------------------
`default_nettype none

package pfpa_pkg;

    localparam int REQ_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 8;
    localparam int AVG_W   = 20;
    localparam int WORD_W  = 16;
    localparam int FRAC_W  = 4;
    localparam int NUM_RD  = 3;
    localparam int POS_W   = 5;

    localparam int OUT_BITS = COUNT_W + NUM_RD * AVG_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int RING_DEPTH_DEF = 8;

    localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BYTE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BAD_SUM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AVG     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h42;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h4D;

    localparam logic [POS_W-1:0] POS_SYNC2   = 5'd1;
    localparam logic [POS_W-1:0] POS_PM1_HI  = 5'd4;
    localparam logic [POS_W-1:0] POS_PM1_LO  = 5'd5;
    localparam logic [POS_W-1:0] POS_PM25_HI = 5'd6;
    localparam logic [POS_W-1:0] POS_PM25_LO = 5'd7;
    localparam logic [POS_W-1:0] POS_PM10_HI = 5'd8;
    localparam logic [POS_W-1:0] POS_PM10_LO = 5'd9;
    localparam logic [POS_W-1:0] SUM_LEN     = 5'd30;
    localparam logic [POS_W-1:0] POS_CHK_LO  = 5'd31;

endpackage : pfpa_pkg

`default_nettype wire

// ----- hdl/particle_frame_parser_averager_unit.sv -----
// ----------------------------------------------------------------------------
// Particle frame parser and averager
// Hunts for framed sensor records in a byte stream, checks their sums, keeps
// the last readings in a ring and averages them on request.
// ----------------------------------------------------------------------------
// A received byte that does not complete a frame and a start item are each
// taken in the idle state, and a finish with an empty ring goes straight to
// the result. The byte that completes a frame passes through the checksum
// compare and the ring write in S_FRAME, then the result in S_EMIT. A finish
// with held entries does one memory read and three passes through the shared
// adder per entry, then one restoring division per reading, one quotient bit a
// cycle. An item that gives a result stays in its last state for as long as
// the previous result has not been taken. The input is not ready while an item
// is at work; the result sits in an output register, so bytes that give no
// result are still taken while it waits.
`default_nettype none

module particle_frame_parser_averager_unit #(
    parameter int RING_DEPTH = pfpa_pkg::RING_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: rx_byte.
    input  wire logic [pfpa_pkg::BYTE_W-1:0]  s_tdata,
    // Fields from bit 0: req_type.
    input  wire logic [pfpa_pkg::REQ_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // Fields from bit 0: frames_stored, pm1_average, pm25_average, pm10_average.
    output logic [pfpa_pkg::OUT_W-1:0]        m_tdata,
    // Fields from bit 0: event_kind.
    output logic [pfpa_pkg::KIND_W-1:0]       m_tuser
);

    import pfpa_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int ACC_W = WORD_W + CNT_W;
    localparam int DVD_W = ACC_W + FRAC_W;
    localparam int BC_W  = $clog2(DVD_W + 1);
    localparam int ENT_W = NUM_RD * WORD_W;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);
    localparam logic [1:0]       LAST_SEL  = 2'(NUM_RD - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAME,
        S_RD,
        S_ACC,
        S_DIV_LOAD,
        S_DIV,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WORD_W-1:0]    sum_reg, sum_next;
    logic [WORD_W-1:0]    chk_reg, chk_next;
    logic [WORD_W-1:0]    raw_reg [NUM_RD];
    logic [WORD_W-1:0]    raw_next [NUM_RD];
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [1:0]           sel_reg, sel_next;
    logic [ACC_W-1:0]     acc_reg [NUM_RD];
    logic [ACC_W-1:0]     acc_next [NUM_RD];
    logic [AVG_W-1:0]     avg_reg [NUM_RD];
    logic [AVG_W-1:0]     avg_next [NUM_RD];
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]     dq_reg, dq_next;
    logic [BC_W-1:0]      bit_reg, bit_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [KIND_W-1:0]    m_tuser_reg, m_tuser_next;

    logic [ENT_W-1:0]     ring_mem [RING_DEPTH];
    logic [ENT_W-1:0]     rd_data_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     rd_addr;

    logic                 accept;
    logic [BYTE_W-1:0]    rx_byte;
    logic [CNT_W:0]       trial;
    logic                 trial_ge;
    logic [WORD_W-1:0]    acc_field;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rx_byte  = s_tdata;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign rd_addr  = k_reg[IDX_W-1:0];
    assign mem_we   = (state_reg == S_FRAME) && (sum_reg == chk_reg);

    assign trial    = {rem_reg, dq_reg[DVD_W-1]};
    assign trial_ge = (trial >= {1'b0, count_reg});

    always_comb
    begin
        case (sel_reg)
            2'd0:    acc_field = rd_data_reg[WORD_W-1:0];
            2'd1:    acc_field = rd_data_reg[2*WORD_W-1:WORD_W];
            default: acc_field = rd_data_reg[ENT_W-1:2*WORD_W];
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        chk_next      = chk_reg;
        raw_next      = raw_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        sel_next      = sel_reg;
        acc_next      = acc_reg;
        avg_next      = avg_reg;
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        bit_next      = bit_reg;
        kind_next     = kind_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        REQ_START:
                        begin
                            pos_next   = '0;
                            head_next  = '0;
                            count_next = '0;
                        end
                        REQ_BYTE:
                        begin
                            if (pos_reg == '0 && rx_byte != SYNC_FIRST)
                            begin
                                pos_next = '0;
                            end
                            else if (pos_reg == POS_SYNC2 && rx_byte != SYNC_SECOND)
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                                if (pos_reg == '0)
                                begin
                                    sum_next = WORD_W'(rx_byte);
                                end
                                else if (pos_reg < SUM_LEN)
                                begin
                                    sum_next = sum_reg + WORD_W'(rx_byte);
                                end
                                case (pos_reg)
                                    POS_PM1_HI:  raw_next[0][15:8] = rx_byte;
                                    POS_PM1_LO:  raw_next[0][7:0]  = rx_byte;
                                    POS_PM25_HI: raw_next[1][15:8] = rx_byte;
                                    POS_PM25_LO: raw_next[1][7:0]  = rx_byte;
                                    POS_PM10_HI: raw_next[2][15:8] = rx_byte;
                                    POS_PM10_LO: raw_next[2][7:0]  = rx_byte;
                                    SUM_LEN:     chk_next[15:8]    = rx_byte;
                                    POS_CHK_LO:
                                    begin
                                        chk_next[7:0] = rx_byte;
                                        pos_next      = '0;
                                        state_next    = S_FRAME;
                                    end
                                    default:     ;
                                endcase
                            end
                        end
                        REQ_FINISH:
                        begin
                            for (int r = 0; r < NUM_RD; r++)
                            begin
                                acc_next[r] = '0;
                                avg_next[r] = '0;
                            end
                            k_next   = '0;
                            sel_next = '0;
                            if (count_reg == '0)
                            begin
                                kind_next  = KIND_EMPTY;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FRAME:
            begin
                for (int r = 0; r < NUM_RD; r++)
                begin
                    avg_next[r] = '0;
                end
                if (sum_reg == chk_reg)
                begin
                    kind_next = KIND_GOOD;
                    head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                    if (count_reg != FULL_CNT)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    kind_next = KIND_BAD_SUM;
                end
                state_next = S_EMIT;
            end
            S_RD:
            begin
                sel_next   = '0;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next[sel_reg] = acc_reg[sel_reg] + ACC_W'(acc_field);
                if (sel_reg == LAST_SEL)
                begin
                    sel_next = '0;
                    k_next   = k_reg + 1'b1;
                    if (k_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_DIV_LOAD;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
                else
                begin
                    sel_next = sel_reg + 1'b1;
                end
            end
            S_DIV_LOAD:
            begin
                rem_next   = '0;
                dq_next    = {acc_reg[sel_reg], {FRAC_W{1'b0}}};
                bit_next   = BC_W'(DVD_W);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = trial_ge ? CNT_W'(trial - {1'b0, count_reg}) : trial[CNT_W-1:0];
                dq_next  = {dq_reg[DVD_W-2:0], trial_ge};
                bit_next = bit_reg - 1'b1;
                if (bit_reg == BC_W'(1))
                begin
                    avg_next[sel_reg] = dq_next[AVG_W-1:0];
                    if (sel_reg == LAST_SEL)
                    begin
                        kind_next  = KIND_AVG;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = S_DIV_LOAD;
                    end
                end
            end
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = kind_reg;
                    m_tdata_next  = OUT_W'({avg_reg[2], avg_reg[1], avg_reg[0],
                                            COUNT_W'(count_reg)});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            sel_reg      <= '0;
            bit_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            sel_reg      <= sel_next;
            bit_reg      <= bit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        chk_reg     <= chk_next;
        raw_reg     <= raw_next;
        acc_reg     <= acc_next;
        avg_reg     <= avg_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        kind_reg    <= kind_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[head_reg] <= {raw_reg[2], raw_reg[1], raw_reg[0]};
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("Ring count beyond the ring depth.");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_SLOT)
        else $error("Ring head beyond the last slot.");

    a_avg_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_AVG) |-> (m_tdata[COUNT_W-1:0] != '0))
        else $error("Averages reported with an empty ring.");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == REQ_START) |=>
        (count_reg == '0 && head_reg == '0 && pos_reg == '0))
        else $error("Start item did not clear the ring and position.");

    a_div_on_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV || state_reg == S_ACC) |-> (count_reg != '0))
        else $error("Averaging pass running with no entries held.");
`endif

endmodule : particle_frame_parser_averager_unit

`default_nettype wire
